// ----- sv/rtp_mid_extension_stamper_defines.svh -----
// Assertion macros shared by the RTL of the MID extension stamper.
`ifndef RTP_MID_EXTENSION_STAMPER_DEFINES_SVH
`define RTP_MID_EXTENSION_STAMPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rms_pkg.sv -----
// Types, constants and helpers shared by the MID extension stamper modules.
`default_nettype none
package rms_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int MAX_MID_BYTES    = 32;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ADDR_W           = $clog2(MAX_PACKET_BYTES);
    localparam int MID_W            = MAX_MID_BYTES * 8;
    localparam int MIDX_W           = $clog2(MAX_MID_BYTES);
    localparam int MLEN_W           = 6;
    localparam int HB_W             = 7;

    localparam logic [15:0] PROFILE_ONE  = 16'hBEDE;
    localparam logic [15:0] PROFILE_TWO  = 16'h1000;
    localparam logic [15:0] PROFILE_MASK = 16'hFFF0;
    localparam logic [7:0]  X_BIT        = 8'h10;
    localparam logic [7:0]  ONE_ID_MAX   = 8'd14;
    localparam logic [7:0]  ONE_LEN_MAX  = 8'd16;
    localparam logic [3:0]  ID_RESERVED  = 4'hF;
    localparam logic [CNT_W-1:0] HDR_FIXED = CNT_W'(12);

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_REWRITTEN = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_BYTE      = 3'd4,
        ST_NOTHING   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_DROPPING,
        PH_READY
    } phase_t;

    typedef enum logic [2:0] {
        CFG_EXT_ID,
        CFG_MID_LEN,
        CFG_MID_WORD_0,
        CFG_MID_WORD_1,
        CFG_MID_WORD_2,
        CFG_MID_WORD_3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_WRITE,
        DP_RD_ISSUE,
        DP_RD_TAKE,
        DP_REJECT,
        DP_LATCH,
        DP_HDR_CAP,
        DP_SCAN_INIT,
        DP_ID_TAKE,
        DP_LEN_TAKE,
        DP_MATCH_STEP,
        DP_SET_UNCH,
        DP_BUILD
    } dp_op_t;

    typedef enum logic [1:0] {
        AS_HDR,
        AS_SCAN,
        AS_OUT
    } addr_sel_t;

    typedef enum logic [4:0] {
        CS_IDLE,
        CS_RD_W,
        CS_CHK,
        CS_HDR_ISS,
        CS_HDR_W,
        CS_HCHK,
        CS_SCAN,
        CS_ID_W,
        CS_LEN_ISS,
        CS_LEN_W,
        CS_MCHK,
        CS_M_ISS,
        CS_M_W,
        CS_UNCH,
        CS_BUILD,
        CS_REJ,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t    op;
        addr_sel_t asel;
        logic      emit;
        status_t   status;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_ready;
        logic wr_drop;
        logic chk_bad;
        logic chk_x;
        logic chk_short;
        logic hdr_last;
        logic hc_bad;
        logic scan_end;
        logic id_zero;
        logic one_form;
        logic id_bad;
        logic id_hit;
        logic len_bad;
        logic len_hit;
        logic len_eq;
        logic m_done;
        logic m_eq;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] mid_byte(input logic [MID_W-1:0] m,
                                            input logic [MIDX_W-1:0] i);
        return m[i*8 +: 8];
    endfunction

endpackage
`default_nettype wire

// ----- sv/rtp_mid_extension_stamper.sv -----
// RTP MID header extension stamper: load a packet, stamp the MID element, read it back.
// One word is taken at a time. A packet byte write has tuser 0, a read of an output
// byte has tuser 1. The final byte of a packet adds the header check and, when an
// extension block is present, the element scan through the single read port of the
// 2048-byte packet store, which reads one-byte and two-byte element headers, zero pads
// and compared MID bytes in turn.
// Every word yields one result word whose tuser is its status; a finished result waits
// in an output register while the next word is already taken.
`default_nettype none
`include "rtp_mid_extension_stamper_defines.svh"
module rtp_mid_extension_stamper
    import rms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [2:0]       m_tuser,   // [2:0] status
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `RMS_ASSERT_IMP(a_last_only_on_byte, m_tvalid && m_tlast, m_tuser == ST_BYTE, "out_last without byte")
    `RMS_ASSERT_IMP(a_data_zero_otherwise, m_tvalid && (m_tuser != ST_BYTE), m_tdata == 8'h00, "stray data")
    `RMS_ASSERT_NXT(a_one_word_at_a_time, s_tvalid && s_tready, !s_tready, "word taken while busy")
    `RMS_ASSERT_IMP(a_emit_into_free_slot, cmd.emit, !m_tvalid || m_tready, "result overwritten")

endmodule
`default_nettype wire

// ----- sv/rms_ctrl.sv -----
// Sequencer for load, header check, element scan, rewrite setup and read-back.
`default_nettype none
module rms_ctrl
    import rms_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    input  wire logic     s_tuser,
    input  wire logic     s_tlast,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    status_t     status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CS_IDLE;
            status_reg <= ST_NOTHING;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = DP_NOP;
        cmd.asel    = AS_SCAN;
        cmd.emit    = 1'b0;
        cmd.status  = status_reg;
        s_tready    = (state_reg == CS_IDLE);
        unique case (state_reg)
            CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        if (stat.phase_ready)
                        begin
                            cmd.op      = DP_RD_ISSUE;
                            cmd.asel    = AS_OUT;
                            status_next = ST_BYTE;
                            state_next  = CS_RD_W;
                        end
                        else
                        begin
                            status_next = ST_NOTHING;
                            state_next  = CS_DONE;
                        end
                    end
                    else
                    begin
                        cmd.op = DP_WRITE;
                        priority if (!s_tlast)
                        begin
                            status_next = ST_ACCEPTED;
                            state_next  = CS_DONE;
                        end
                        else if (stat.wr_drop)
                        begin
                            status_next = ST_REJECTED;
                            state_next  = CS_DONE;
                        end
                        else
                        begin
                            state_next = CS_CHK;
                        end
                    end
                end
            end
            CS_RD_W:
            begin
                cmd.op     = DP_RD_TAKE;
                state_next = CS_DONE;
            end
            CS_CHK:
            begin
                cmd.op = DP_LATCH;
                priority if (stat.chk_bad)
                    state_next = CS_REJ;
                else if (!stat.chk_x)
                    state_next = CS_BUILD;
                else if (stat.chk_short)
                    state_next = CS_REJ;
                else
                    state_next = CS_HDR_ISS;
            end
            CS_HDR_ISS:
            begin
                cmd.asel   = AS_HDR;
                state_next = CS_HDR_W;
            end
            CS_HDR_W:
            begin
                cmd.op     = DP_HDR_CAP;
                state_next = stat.hdr_last ? CS_HCHK : CS_HDR_ISS;
            end
            CS_HCHK:
            begin
                if (stat.hc_bad)
                    state_next = CS_REJ;
                else
                begin
                    cmd.op     = DP_SCAN_INIT;
                    state_next = CS_SCAN;
                end
            end
            CS_SCAN:
            begin
                state_next = stat.scan_end ? CS_BUILD : CS_ID_W;
            end
            CS_ID_W:
            begin
                cmd.op = DP_ID_TAKE;
                priority if (stat.id_zero)
                    state_next = CS_SCAN;
                else if (stat.id_bad)
                    state_next = CS_REJ;
                else if (!stat.one_form)
                    state_next = CS_LEN_ISS;
                else if (stat.id_hit)
                    state_next = CS_MCHK;
                else
                    state_next = CS_SCAN;
            end
            CS_LEN_ISS:
            begin
                state_next = CS_LEN_W;
            end
            CS_LEN_W:
            begin
                cmd.op = DP_LEN_TAKE;
                priority if (stat.len_bad)
                    state_next = CS_REJ;
                else if (stat.len_hit)
                    state_next = CS_MCHK;
                else
                    state_next = CS_SCAN;
            end
            CS_MCHK:
            begin
                state_next = stat.len_eq ? CS_M_ISS : CS_BUILD;
            end
            CS_M_ISS:
            begin
                state_next = stat.m_done ? CS_UNCH : CS_M_W;
            end
            CS_M_W:
            begin
                cmd.op     = DP_MATCH_STEP;
                state_next = stat.m_eq ? CS_M_ISS : CS_BUILD;
            end
            CS_UNCH:
            begin
                cmd.op      = DP_SET_UNCH;
                status_next = ST_UNCHANGED;
                state_next  = CS_DONE;
            end
            CS_BUILD:
            begin
                cmd.op      = DP_BUILD;
                status_next = ST_REWRITTEN;
                state_next  = CS_DONE;
            end
            CS_REJ:
            begin
                cmd.op      = DP_REJECT;
                status_next = ST_REJECTED;
                state_next  = CS_DONE;
            end
            CS_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/rms_dp.sv -----
// Packet store, configuration, scan registers, output byte mapping and result register.
`default_nettype none
module rms_dp
    import rms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic [2:0]       m_tuser
);

    logic [7:0] mem [MAX_PACKET_BYTES];
    logic [7:0] mem_q;

    logic [7:0]        ext_id_reg;
    logic [MLEN_W-1:0] mid_len_reg;
    logic [MID_W-1:0]  mid_reg;
    logic [7:0]        lat_id_reg;
    logic [MLEN_W-1:0] lat_len_reg;
    logic [MID_W-1:0]  lat_mid_reg;

    phase_t            phase_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        b0_reg;
    logic [1:0]        hidx_reg;
    logic [31:0]       hdr_reg;
    logic              one_reg;
    logic              had_reg;
    logic [CNT_W-1:0]  cur_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [7:0]        id_reg;
    logic [7:0]        len_reg;
    logic [MLEN_W-1:0] mi_reg;
    logic [HB_W-1:0]   hb_reg;
    logic [CNT_W-1:0]  words_reg;
    logic [CNT_W-1:0]  oldlen_reg;
    logic [CNT_W-1:0]  delta_reg;
    logic [CNT_W-1:0]  olen_reg;
    logic [MLEN_W-1:0] elen_reg;
    logic              unch_reg;
    logic [CNT_W-1:0]  rp_reg;
    logic              use_mem_reg;
    logic [7:0]        const_reg;
    logic [7:0]        res_byte_reg;
    logic              res_last_reg;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg;

    logic [CNT_W-1:0]  eff;
    logic              wr_drop;
    logic              mem_we;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  avail;
    logic [17:0]       ext18;
    logic [15:0]       prof;
    logic              one_p;
    logic [CNT_W-1:0]  cur1;
    logic [CNT_W-1:0]  rem;
    logic [7:0]        len1;
    logic              id_hit;
    logic              len_hit;
    logic [CNT_W-1:0]  rd_addr;
    logic              src_mem;
    logic [7:0]        src_const;
    logic [CNT_W-1:0]  out_addr;
    logic [CNT_W-1:0]  elen;
    logic [CNT_W-1:0]  words;
    logic [CNT_W-1:0]  oldlen_b;

    // Store write address restarts at zero when a new packet follows an output
    assign eff     = (phase_reg == PH_READY) ? '0 : count_reg;
    assign wr_drop = (eff == CNT_W'(MAX_PACKET_BYTES));
    assign mem_we  = (cmd.op == DP_WRITE) && !wr_drop;

    assign base  = HDR_FIXED + {{(CNT_W-6){1'b0}}, b0_reg[3:0], 2'b00};
    assign start = base + CNT_W'(4);
    assign avail = count_reg - base - CNT_W'(4);
    assign ext18 = {hdr_reg[15:0], 2'b00};
    assign prof  = hdr_reg[31:16];
    assign one_p = (prof == PROFILE_ONE);
    assign cur1  = cur_reg + CNT_W'(1);
    assign rem   = size_reg - cur1;
    assign len1  = {4'h0, mem_q[3:0]} + 8'd1;
    assign id_hit  = one_reg && ({4'h0, mem_q[7:4]} == lat_id_reg);
    assign len_hit = (id_reg == lat_id_reg);

    always_comb
    begin
        stat.phase_ready = (phase_reg == PH_READY);
        stat.wr_drop     = wr_drop;
        stat.chk_bad     = (ext_id_reg == 8'h00) || (mid_len_reg == '0)
                        || (mid_len_reg > MLEN_W'(MAX_MID_BYTES))
                        || (count_reg < HDR_FIXED) || (b0_reg[7:6] != 2'b10)
                        || ((count_reg - HDR_FIXED)
                            < {{(CNT_W-6){1'b0}}, b0_reg[3:0], 2'b00});
        stat.chk_x       = b0_reg[4];
        stat.chk_short   = (count_reg - base) < CNT_W'(4);
        stat.hdr_last    = (hidx_reg == 2'd3);
        stat.hc_bad      = (ext18 > 18'(avail))
                        || (!one_p && ((prof & PROFILE_MASK) != PROFILE_TWO))
                        || (one_p && ((lat_id_reg > ONE_ID_MAX)
                                      || ({2'b00, lat_len_reg} > ONE_LEN_MAX)));
        stat.scan_end    = (cur_reg >= size_reg);
        stat.id_zero     = (mem_q == 8'h00);
        stat.one_form    = one_reg;
        stat.id_bad      = one_reg ? ((mem_q[7:4] == ID_RESERVED)
                                      || (CNT_W'(len1) > rem))
                                   : (cur1 >= size_reg);
        stat.id_hit      = id_hit;
        stat.len_bad     = CNT_W'(mem_q) > rem;
        stat.len_hit     = len_hit;
        stat.len_eq      = (len_reg == {2'b00, lat_len_reg});
        stat.m_done      = (mi_reg == lat_len_reg);
        stat.m_eq        = (mem_q == mid_byte(lat_mid_reg, mi_reg[MIDX_W-1:0]));
        stat.out_free    = !m_valid_reg || m_tready;
    end

    // Map the read pointer onto a stored byte or a generated byte
    always_comb
    begin
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] hb;
        logic [CNT_W-1:0] e;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] w4;
        i         = rp_reg;
        hb        = CNT_W'(hb_reg);
        e         = i - hb - CNT_W'(4);
        k         = e - oldlen_reg;
        w4        = {words_reg[CNT_W-3:0], 2'b00};
        src_mem   = 1'b1;
        src_const = 8'h00;
        out_addr  = i;
        priority if (unch_reg)
            src_mem = 1'b1;
        else if (i == '0)
        begin
            src_mem   = 1'b0;
            src_const = b0_reg | X_BIT;
        end
        else if (i < hb)
            src_mem = 1'b1;
        else if (i < hb + CNT_W'(2))
        begin
            src_mem = had_reg;
            if (one_reg)
                src_const = (i == hb) ? PROFILE_ONE[15:8] : PROFILE_ONE[7:0];
            else
                src_const = (i == hb) ? PROFILE_TWO[15:8] : PROFILE_TWO[7:0];
        end
        else if (i == hb + CNT_W'(2))
        begin
            src_mem   = 1'b0;
            src_const = 8'(words_reg >> 8);
        end
        else if (i == hb + CNT_W'(3))
        begin
            src_mem   = 1'b0;
            src_const = words_reg[7:0];
        end
        else if (e < w4)
        begin
            if (e < oldlen_reg)
                src_mem = 1'b1;
            else
            begin
                src_mem = 1'b0;
                if (k >= CNT_W'(elen_reg))
                    src_const = 8'h00;
                else if (one_reg)
                    src_const = (k == '0) ? {lat_id_reg[3:0], 4'(lat_len_reg - 1'b1)}
                              : mid_byte(lat_mid_reg, MIDX_W'(k - CNT_W'(1)));
                else if (k == '0)
                    src_const = lat_id_reg;
                else if (k == CNT_W'(1))
                    src_const = {2'b00, lat_len_reg};
                else
                    src_const = mid_byte(lat_mid_reg, MIDX_W'(k - CNT_W'(2)));
            end
        end
        else
            out_addr = i - delta_reg;
    end

    always_comb
    begin
        unique case (cmd.asel)
            AS_HDR:  rd_addr = base + CNT_W'(hidx_reg);
            AS_SCAN: rd_addr = start + cur_reg + CNT_W'(mi_reg);
            AS_OUT:  rd_addr = out_addr;
            default: rd_addr = out_addr;
        endcase
    end

    // Rewrite geometry
    assign elen     = CNT_W'(lat_len_reg) + (one_reg ? CNT_W'(1) : CNT_W'(2));
    assign oldlen_b = had_reg ? oldlen_reg : '0;
    assign words    = (oldlen_b + elen + CNT_W'(3)) >> 2;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[eff[ADDR_W-1:0]] <= s_tdata;
        mem_q <= mem[rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_id_reg  <= '0;
            mid_len_reg <= '0;
            mid_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EXT_ID:     ext_id_reg          <= cfg_data[7:0];
                CFG_MID_LEN:    mid_len_reg         <= cfg_data[MLEN_W-1:0];
                CFG_MID_WORD_0: mid_reg[63:0]       <= cfg_data;
                CFG_MID_WORD_1: mid_reg[127:64]     <= cfg_data;
                CFG_MID_WORD_2: mid_reg[191:128]    <= cfg_data;
                CFG_MID_WORD_3: mid_reg[255:192]    <= cfg_data;
                default:        ext_id_reg          <= ext_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOADING;
            count_reg <= '0;
            rp_reg    <= '0;
            hidx_reg  <= '0;
            mi_reg    <= '0;
            unch_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                DP_WRITE:
                begin
                    if (wr_drop)
                    begin
                        phase_reg <= s_tlast ? PH_LOADING : PH_DROPPING;
                        count_reg <= s_tlast ? '0 : eff;
                    end
                    else
                    begin
                        phase_reg <= PH_LOADING;
                        count_reg <= eff + CNT_W'(1);
                    end
                end
                DP_RD_TAKE:
                begin
                    rp_reg <= rp_reg + CNT_W'(1);
                    if (rp_reg + CNT_W'(1) == olen_reg)
                    begin
                        phase_reg <= PH_LOADING;
                        count_reg <= '0;
                    end
                end
                DP_REJECT:
                begin
                    phase_reg <= PH_LOADING;
                    count_reg <= '0;
                end
                DP_LATCH:
                begin
                    hidx_reg <= '0;
                    mi_reg   <= '0;
                end
                DP_HDR_CAP:
                    hidx_reg <= hidx_reg + 2'd1;
                DP_MATCH_STEP:
                    mi_reg <= mi_reg + MLEN_W'(1);
                DP_SET_UNCH:
                begin
                    unch_reg  <= 1'b1;
                    phase_reg <= PH_READY;
                    rp_reg    <= '0;
                end
                DP_BUILD:
                begin
                    unch_reg  <= 1'b0;
                    phase_reg <= PH_READY;
                    rp_reg    <= '0;
                end
                default:
                    rp_reg <= rp_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_WRITE:
                if (!wr_drop && (eff == '0))
                    b0_reg <= s_tdata;
            DP_RD_ISSUE:
            begin
                use_mem_reg <= src_mem;
                const_reg   <= src_const;
            end
            DP_RD_TAKE:
            begin
                res_byte_reg <= use_mem_reg ? mem_q : const_reg;
                res_last_reg <= (rp_reg + CNT_W'(1) == olen_reg);
            end
            DP_LATCH:
            begin
                lat_id_reg  <= ext_id_reg;
                lat_len_reg <= mid_len_reg;
                lat_mid_reg <= mid_reg;
                had_reg     <= 1'b0;
                oldlen_reg  <= '0;
                one_reg     <= (ext_id_reg <= ONE_ID_MAX)
                            && ({2'b00, mid_len_reg} <= ONE_LEN_MAX);
            end
            DP_HDR_CAP:
                hdr_reg <= {hdr_reg[23:0], mem_q};
            DP_SCAN_INIT:
            begin
                one_reg    <= one_p;
                had_reg    <= 1'b1;
                oldlen_reg <= ext18[CNT_W-1:0];
                size_reg   <= ext18[CNT_W-1:0];
                cur_reg    <= '0;
            end
            DP_ID_TAKE:
            begin
                id_reg  <= mem_q;
                len_reg <= len1;
                if (one_reg && !stat.id_zero && !id_hit)
                    cur_reg <= cur1 + CNT_W'(len1);
                else
                    cur_reg <= cur1;
            end
            DP_LEN_TAKE:
            begin
                len_reg <= mem_q;
                cur_reg <= len_hit ? cur1 : cur1 + CNT_W'(mem_q);
            end
            DP_SET_UNCH:
                olen_reg <= count_reg;
            DP_BUILD:
            begin
                hb_reg    <= base[HB_W-1:0];
                words_reg <= words;
                elen_reg  <= elen[MLEN_W-1:0];
                if (had_reg)
                begin
                    delta_reg <= (words << 2) - oldlen_reg;
                    olen_reg  <= count_reg + (words << 2) - oldlen_reg;
                end
                else
                begin
                    delta_reg <= (words << 2) + CNT_W'(4);
                    olen_reg  <= count_reg + (words << 2) + CNT_W'(4);
                end
            end
            default:
                const_reg <= const_reg;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_status_reg <= cmd.status;
            m_byte_reg   <= (cmd.status == ST_BYTE) ? res_byte_reg : 8'h00;
            m_last_reg   <= (cmd.status == ST_BYTE) && res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire
